[hw/rtl/um_pkg.sv]
// Shared constants and types for the universal machine execute core.
package um_pkg;

  localparam int WORD_W = 32;
  localparam int REG_N  = 8;
  localparam int RIDX_W = 3;
  localparam int ACT_W  = 4;
  localparam int OP_W   = 4;

  typedef logic [WORD_W-1:0] word_t;
  typedef logic [RIDX_W-1:0] ridx_t;
  typedef logic [ACT_W-1:0]  act_t;
  typedef logic [OP_W-1:0]   op_t;

  // Result action codes
  localparam act_t ACT_DONE  = 4'd0;
  localparam act_t ACT_OUT   = 4'd1;
  localparam act_t ACT_READ  = 4'd2;
  localparam act_t ACT_WRITE = 4'd3;
  localparam act_t ACT_MAP   = 4'd4;
  localparam act_t ACT_UNMAP = 4'd5;
  localparam act_t ACT_LOADP = 4'd6;
  localparam act_t ACT_HALT  = 4'd7;
  localparam act_t ACT_FAULT = 4'd8;

  // Command codes
  localparam logic CMD_EXEC  = 1'b0;
  localparam logic CMD_REPLY = 1'b1;

  // Opcodes
  localparam op_t OP_CMOV    = 4'd0;
  localparam op_t OP_SLOAD   = 4'd1;
  localparam op_t OP_SSTORE  = 4'd2;
  localparam op_t OP_ADD     = 4'd3;
  localparam op_t OP_MUL     = 4'd4;
  localparam op_t OP_DIV     = 4'd5;
  localparam op_t OP_NAND    = 4'd6;
  localparam op_t OP_HALT    = 4'd7;
  localparam op_t OP_MAP     = 4'd8;
  localparam op_t OP_UNMAP   = 4'd9;
  localparam op_t OP_OUTPUT  = 4'd10;
  localparam op_t OP_INPUT   = 4'd11;
  localparam op_t OP_LOADP   = 4'd12;
  localparam op_t OP_LOADIMM = 4'd13;

  // Instruction field layout
  localparam int OP_LSB        = 28;
  localparam int IMM_BITS      = 25;
  localparam int IMM_REG_SHIFT = 32 - 7;
  localparam int A_LSB         = 6;
  localparam int B_LSB         = 3;
  localparam int C_LSB         = 0;
  localparam int BYTE_W        = 8;
  localparam word_t BYTE_MAX   = 32'd255;

endpackage

[hw/rtl/um_instruction_execute.sv]
// Sequence: halt, fault, reply, load immediate and input go from accept straight to the result
// hand-off; register operations and memory requests pass through a register read step first,
// segment store and multiply take one more step, and divide waits on the bit-serial divider.
// One item at a time, and a stalled output holds the input.
// Reset: synchronous, clears halted, awaiting reply and the register valid bits,
// so every register reads as zero until written.
module um_instruction_execute (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             in_valid,
  output logic                             in_ready,
  input  logic                             command,
  input  logic [31:0]                      instr_word,
  input  logic [7:0]                       in_byte,
  input  logic                             in_eof,
  input  logic [31:0]                      reply_data,
  output logic                             out_valid,
  input  logic                             out_ready,
  output logic [um_pkg::ACT_W-1:0]         action,
  output logic [7:0]                       out_byte,
  output logic [31:0]                      seg_id,
  output logic [31:0]                      seg_offset,
  output logic [31:0]                      write_data,
  output logic [31:0]                      new_pc
);
  import um_pkg::*;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_READ,
    ST_READA,
    ST_MUL,
    ST_DIV,
    ST_FIN
  } state_t;

  state_t            state;
  logic              halted;
  logic              awaiting;
  ridx_t             pending_dest;
  logic [REG_N-1:0]  reg_vld;

  // Latched item fields
  op_t               op_lat;
  ridx_t             a_lat;
  ridx_t             b_lat;
  ridx_t             c_lat;
  word_t             rb_lat;
  word_t             rc_lat;
  word_t             prod;

  // Pending result
  act_t              res_action;
  logic [BYTE_W-1:0] res_byte;
  word_t             res_seg;
  word_t             res_off;
  word_t             res_wd;
  word_t             res_pc;

  // Register file port signals
  logic              wr_en;
  ridx_t             wr_addr;
  word_t             wr_data;
  ridx_t             rd_addr0;
  ridx_t             rd_addr1;
  word_t             q0;
  word_t             q1;
  word_t             rb_now;
  word_t             rc_now;
  word_t             ra_now;

  logic              accept;
  op_t               in_op;
  logic              div_start;
  logic              div_done;
  word_t             div_quo;

  assign in_ready = (state == ST_IDLE);
  assign accept   = in_valid && in_ready;
  assign in_op    = instr_word[OP_LSB +: OP_W];

  // Unwritten registers read as zero
  assign rb_now = reg_vld[b_lat] ? q0 : '0;
  assign rc_now = reg_vld[c_lat] ? q1 : '0;
  assign ra_now = reg_vld[a_lat] ? q0 : '0;

  assign div_start = (state == ST_READ) && (op_lat == OP_DIV) && (rc_now != '0);

  // Register file read addresses
  always_comb begin
    rd_addr0 = instr_word[B_LSB +: RIDX_W];
    rd_addr1 = instr_word[C_LSB +: RIDX_W];
    if (state == ST_READ) begin
      rd_addr0 = a_lat;
    end
  end

  // Register file write selection
  always_comb begin
    wr_en   = 1'b0;
    wr_addr = a_lat;
    wr_data = '0;
    case (state)
      ST_IDLE: begin
        if (accept && !halted) begin
          if (command == CMD_REPLY) begin
            wr_en   = awaiting;
            wr_addr = pending_dest;
            wr_data = reply_data;
          end else if (!awaiting) begin
            if (in_op == OP_LOADIMM) begin
              wr_en   = 1'b1;
              wr_addr = instr_word[IMM_REG_SHIFT +: RIDX_W];
              wr_data = {{(WORD_W-IMM_BITS){1'b0}}, instr_word[IMM_BITS-1:0]};
            end else if (in_op == OP_INPUT) begin
              wr_en   = 1'b1;
              wr_addr = instr_word[C_LSB +: RIDX_W];
              wr_data = in_eof ? '1 : {{(WORD_W-BYTE_W){1'b0}}, in_byte};
            end
          end
        end
      end
      ST_READ: begin
        case (op_lat)
          OP_CMOV: begin
            wr_en   = (rc_now != '0);
            wr_data = rb_now;
          end
          OP_ADD: begin
            wr_en   = 1'b1;
            wr_data = rb_now + rc_now;
          end
          OP_NAND: begin
            wr_en   = 1'b1;
            wr_data = ~(rb_now & rc_now);
          end
          default: wr_en = 1'b0;
        endcase
      end
      ST_MUL: begin
        wr_en   = 1'b1;
        wr_data = prod;
      end
      ST_DIV: begin
        wr_en   = div_done;
        wr_data = div_quo;
      end
      default: wr_en = 1'b0;
    endcase
  end

  // Two register file copies give two read ports
  um_ram #(.WIDTH(WORD_W), .DEPTH(REG_N)) u_rf0 (
    .clk   (clk),
    .we    (wr_en),
    .waddr (wr_addr),
    .wdata (wr_data),
    .raddr (rd_addr0),
    .rdata (q0)
  );

  um_ram #(.WIDTH(WORD_W), .DEPTH(REG_N)) u_rf1 (
    .clk   (clk),
    .we    (wr_en),
    .waddr (wr_addr),
    .wdata (wr_data),
    .raddr (rd_addr1),
    .rdata (q1)
  );

  um_div u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (rb_now),
    .divisor  (rc_now),
    .done     (div_done),
    .quotient (div_quo)
  );

  // Sequencer, machine state and output register
  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= ST_IDLE;
      halted       <= 1'b0;
      awaiting     <= 1'b0;
      pending_dest <= '0;
      reg_vld      <= '0;
      out_valid    <= 1'b0;
    end else begin
      if (wr_en) begin
        reg_vld[wr_addr] <= 1'b1;
      end
      // Beat taken; the hand-off step refills it itself
      if (out_valid && out_ready && state != ST_FIN) begin
        out_valid <= 1'b0;
      end

      case (state)
        ST_IDLE: begin
          if (accept) begin
            op_lat     <= in_op;
            a_lat      <= instr_word[A_LSB +: RIDX_W];
            b_lat      <= instr_word[B_LSB +: RIDX_W];
            c_lat      <= instr_word[C_LSB +: RIDX_W];
            res_action <= ACT_DONE;
            res_byte   <= '0;
            res_seg    <= '0;
            res_off    <= '0;
            res_wd     <= '0;
            res_pc     <= '0;
            state      <= ST_FIN;
            if (halted) begin
              res_action <= ACT_HALT;
            end else if (command == CMD_REPLY) begin
              awaiting <= 1'b0;
            end else if (awaiting) begin
              res_action <= ACT_FAULT;
            end else begin
              case (in_op) inside
                OP_LOADIMM, OP_INPUT: res_action <= ACT_DONE;
                OP_HALT: begin
                  halted     <= 1'b1;
                  res_action <= ACT_HALT;
                end
                [OP_CMOV:OP_NAND], [OP_MAP:OP_LOADP]: state <= ST_READ;
                default: res_action <= ACT_FAULT;
              endcase
            end
          end
        end

        ST_READ: begin
          rb_lat <= rb_now;
          rc_lat <= rc_now;
          prod   <= WORD_W'(rb_now * rc_now);
          state  <= ST_FIN;
          case (op_lat)
            OP_SLOAD: begin
              res_action   <= ACT_READ;
              res_seg      <= rb_now;
              res_off      <= rc_now;
              pending_dest <= a_lat;
              awaiting     <= 1'b1;
            end
            OP_SSTORE: state <= ST_READA;
            OP_MUL:    state <= ST_MUL;
            OP_DIV: begin
              if (rc_now == '0) begin
                res_action <= ACT_FAULT;
              end else begin
                state <= ST_DIV;
              end
            end
            OP_MAP: begin
              res_action   <= ACT_MAP;
              res_wd       <= rc_now;
              pending_dest <= b_lat;
              awaiting     <= 1'b1;
            end
            OP_UNMAP: begin
              if (rc_now == '0) begin
                res_action <= ACT_FAULT;
              end else begin
                res_action <= ACT_UNMAP;
                res_seg    <= rc_now;
              end
            end
            OP_OUTPUT: begin
              if (rc_now > BYTE_MAX) begin
                res_action <= ACT_FAULT;
              end else begin
                res_action <= ACT_OUT;
                res_byte   <= rc_now[BYTE_W-1:0];
              end
            end
            OP_LOADP: begin
              res_action <= ACT_LOADP;
              res_seg    <= rb_now;
              res_pc     <= rc_now;
            end
            default: res_action <= ACT_DONE;
          endcase
        end

        ST_READA: begin
          res_action <= ACT_WRITE;
          res_seg    <= ra_now;
          res_off    <= rb_lat;
          res_wd     <= rc_lat;
          state      <= ST_FIN;
        end

        ST_MUL: state <= ST_FIN;

        ST_DIV: begin
          if (div_done) begin
            state <= ST_FIN;
          end
        end

        ST_FIN: begin
          // Hand the result to the output register once it is free
          if (!out_valid || out_ready) begin
            out_valid  <= 1'b1;
            action     <= res_action;
            out_byte   <= res_byte;
            seg_id     <= res_seg;
            seg_offset <= res_off;
            write_data <= res_wd;
            new_pc     <= res_pc;
            state      <= ST_IDLE;
          end
        end

        default: state <= ST_IDLE;
      endcase
    end
  end

  // Once halted, the core stays halted until reset
  a_halt_sticky: assert property (@(posedge clk) disable iff (rst)
    halted |=> halted)
    else $error("halted flag cleared without reset");

  // A halted core answers every beat with halt
  a_halt_answer: assert property (@(posedge clk) disable iff (rst)
    (accept && halted) |=> (state == ST_FIN && res_action == ACT_HALT))
    else $error("halted core did not answer halt");

  // An instruction while a reply is pending is a fault
  a_busy_fault: assert property (@(posedge clk) disable iff (rst)
    (accept && !halted && awaiting && command == CMD_EXEC)
      |=> (state == ST_FIN && res_action == ACT_FAULT))
    else $error("instruction during pending reply not faulted");

  // The divider is never started with a zero divisor
  a_div_nonzero: assert property (@(posedge clk) disable iff (rst)
    div_start |-> (rc_now != '0 && op_lat == OP_DIV))
    else $error("divider started with zero divisor");

endmodule

[hw/rtl/um_ram.sv]
// Generic single-write, single-read RAM with registered read data.
module um_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 8
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port and registered read port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

[hw/rtl/um_div.sv]
// Restoring divider, one quotient bit per cycle.
module um_div (
  input  logic          clk,
  input  logic          rst,
  input  logic          start,
  input  um_pkg::word_t dividend,
  input  um_pkg::word_t divisor,
  output logic          done,
  output um_pkg::word_t quotient
);
  import um_pkg::*;

  localparam int CNT_W = $clog2(WORD_W);

  logic             busy;
  logic [CNT_W-1:0] cnt;
  word_t            rem;
  word_t            dsr;
  logic [WORD_W:0]  shifted;
  logic [WORD_W:0]  diff;

  // Trial subtract of the shifted remainder
  always_comb begin
    shifted = {rem, quotient[WORD_W-1]};
    diff    = shifted - {1'b0, dsr};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      // Pulse once the last quotient bit is in
      done <= !start && busy && (cnt == CNT_W'(WORD_W - 1));
      if (start) begin
        busy     <= 1'b1;
        cnt      <= '0;
        rem      <= '0;
        dsr      <= divisor;
        quotient <= dividend;
      end else if (busy) begin
        rem      <= diff[WORD_W] ? shifted[WORD_W-1:0] : diff[WORD_W-1:0];
        quotient <= {quotient[WORD_W-2:0], ~diff[WORD_W]};
        cnt      <= cnt + 1'b1;
        if (cnt == CNT_W'(WORD_W - 1)) begin
          busy <= 1'b0;
        end
      end
    end
  end

endmodule
